// ===== sv/flpte_pkg.sv =====
// Shared types and constants for the four-level page table engine.
`timescale 1ns / 1ps
`default_nettype none
package flpte_pkg;

  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W = $clog2(ENTRIES_PER_TABLE);
  localparam int ENTRY_W = 64;
  localparam int VA_W = 48;
  localparam int PA_W = 52;
  localparam int OFS_W = 12;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int ROOT_W = 4;
  localparam int FREE_W = 5;

  localparam logic [1:0] CMD_MAP       = 2'd0;
  localparam logic [1:0] CMD_UNMAP     = 2'd1;
  localparam logic [1:0] CMD_TRANSLATE = 2'd2;
  localparam logic [1:0] CMD_RESERVED  = 2'd3;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_ABSENT     = 2'd1;
  localparam logic [1:0] STATUS_ALLOC_FAIL = 2'd2;

  localparam logic REG_ROOT_TABLE_PAGE = 1'b0;
  localparam logic REG_FIRST_FREE_PAGE = 1'b1;

  localparam logic [ENTRY_W-1:0] LINK_FLAGS = 64'h3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [VA_W-1:0]    virt_addr;
    logic [PA_W-1:0]    phys_addr_in;
    logic [ENTRY_W-1:0] entry_flags;
  } cmd_beat_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [PA_W-1:0] phys_addr_out;
  } rsp_beat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

// ===== sv/flpte_ram.sv =====
// Single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module flpte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== sv/four_level_page_table_engine.sv =====
// Four-level page table engine: map, unmap and translate over a table store.
// Usage:
// - cmd channel (cmd_valid/cmd_stall/cmd_beat) takes one command beat: map,
//   unmap or translate of a 48-bit virtual address.
// - rsp channel (rsp_valid/rsp_stall/rsp_beat) returns one beat per command
//   with a status and, for a found translation, the physical address.
// - Commands are handled one at a time; each level of the walk is one read
//   and check through the single port of the table RAM, plus one write where
//   a table is created or the leaf is written.
// - The walk stops early when it faults; a reserved cmd is answered without
//   a walk. A new command is taken the cycle after the result is loaded.
// - The result sits in an output register; a stalled result does not block
//   acceptance of the next command, only the loading of its own result.
// - After reset the table RAM (TABLE_PAGES*512 entries, 8192 by default) is
//   cleared one entry per cycle with cmd_stall held high. APB writes are
//   to be made by the user only while no command is in work (not enforced).
`timescale 1ns / 1ps
`default_nettype none
module four_level_page_table_engine #(
  parameter int TABLE_PAGES = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cmd_valid,
  output logic                                     cmd_stall,
  input  wire flpte_pkg::cmd_beat_t                cmd_beat,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_stall,
  output flpte_pkg::rsp_beat_t                     rsp_beat,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [flpte_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [flpte_pkg::PDATA_W-1:0]       pwdata,
  output logic      [flpte_pkg::PDATA_W-1:0]       prdata,
  output logic                                     pready
);

  localparam int PW = $clog2(TABLE_PAGES);
  localparam int AW = PW + flpte_pkg::IDX_W;
  localparam int DEPTH = TABLE_PAGES * flpte_pkg::ENTRIES_PER_TABLE;
  localparam int NFW_MIN = $clog2(TABLE_PAGES + 1);
  localparam int NFW = (NFW_MIN > flpte_pkg::FREE_W) ? NFW_MIN : flpte_pkg::FREE_W;

  flpte_pkg::state_t state, state_next;

  logic [flpte_pkg::ROOT_W-1:0] root_table_page;
  logic [flpte_pkg::FREE_W-1:0] first_free_page;
  logic [NFW-1:0]               next_free;
  logic [AW-1:0]                clr_addr;
  flpte_pkg::cmd_beat_t         req;
  logic [1:0]                   level;
  logic [PW-1:0]                page;
  logic [1:0]                   res_status;
  logic [flpte_pkg::PA_W-1:0]   res_addr;

  logic                          ram_we;
  logic [AW-1:0]                 ram_addr;
  logic [flpte_pkg::ENTRY_W-1:0] ram_wdata;
  logic [flpte_pkg::ENTRY_W-1:0] entry;

  logic [flpte_pkg::IDX_W-1:0] idx;
  logic cfg_wr, cmd_take, bad_cmd, leaf, present, ptr_ok, can_alloc, rsp_load;

  flpte_ram #(
    .WIDTH(flpte_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(entry)
  );

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign cmd_stall = (state != flpte_pkg::ST_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign bad_cmd   = (cmd_beat.cmd == flpte_pkg::CMD_RESERVED) ||
                     (32'(root_table_page) >= TABLE_PAGES);
  assign leaf      = (level == 2'd3);
  assign present   = entry[0];
  assign ptr_ok    = entry[flpte_pkg::PA_W-1:flpte_pkg::OFS_W] <
                     (flpte_pkg::PA_W - flpte_pkg::OFS_W)'(TABLE_PAGES);
  assign can_alloc = next_free < NFW'(TABLE_PAGES);
  assign rsp_load  = (state == flpte_pkg::ST_RESP) && (!rsp_valid || !rsp_stall);

  always_comb begin
    case (level)
      2'd0:    idx = req.virt_addr[47:39];
      2'd1:    idx = req.virt_addr[38:30];
      2'd2:    idx = req.virt_addr[29:21];
      default: idx = req.virt_addr[20:12];
    endcase
  end

  always_comb begin
    case (paddr[2])
      flpte_pkg::REG_ROOT_TABLE_PAGE: prdata = flpte_pkg::PDATA_W'(root_table_page);
      default:                        prdata = flpte_pkg::PDATA_W'(first_free_page);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      flpte_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = flpte_pkg::ST_IDLE;
      end
      flpte_pkg::ST_IDLE: begin
        if (cmd_take) state_next = bad_cmd ? flpte_pkg::ST_RESP : flpte_pkg::ST_LOOKUP;
      end
      flpte_pkg::ST_LOOKUP: begin
        if (leaf && req.cmd != flpte_pkg::CMD_TRANSLATE) state_next = flpte_pkg::ST_RESP;
        else state_next = flpte_pkg::ST_CHECK;
      end
      flpte_pkg::ST_CHECK: begin
        if (leaf) begin
          state_next = flpte_pkg::ST_RESP;
        end else if (present) begin
          state_next = ptr_ok ? flpte_pkg::ST_LOOKUP : flpte_pkg::ST_RESP;
        end else if (req.cmd == flpte_pkg::CMD_MAP && can_alloc) begin
          state_next = flpte_pkg::ST_LOOKUP;
        end else begin
          state_next = flpte_pkg::ST_RESP;
        end
      end
      flpte_pkg::ST_RESP: begin
        if (rsp_load) state_next = flpte_pkg::ST_IDLE;
      end
      default: state_next = flpte_pkg::ST_CLEAR;
    endcase
  end

  // table RAM port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {page, idx};
    ram_wdata = '0;
    case (state)
      flpte_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      flpte_pkg::ST_LOOKUP: begin
        if (leaf && req.cmd == flpte_pkg::CMD_MAP) begin
          ram_we    = 1'b1;
          ram_wdata = {12'b0, req.phys_addr_in[flpte_pkg::PA_W-1:flpte_pkg::OFS_W],
                       12'b0} | req.entry_flags;
        end else if (leaf && req.cmd == flpte_pkg::CMD_UNMAP) begin
          ram_we = 1'b1;
        end
      end
      flpte_pkg::ST_CHECK: begin
        if (!leaf && !present && req.cmd == flpte_pkg::CMD_MAP && can_alloc) begin
          ram_we    = 1'b1;
          ram_wdata = (flpte_pkg::ENTRY_W'(next_free) << flpte_pkg::OFS_W) |
                      flpte_pkg::LINK_FLAGS;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= flpte_pkg::ST_CLEAR;
      clr_addr        <= '0;
      root_table_page <= '0;
      first_free_page <= flpte_pkg::FREE_W'(1);
      next_free       <= NFW'(1);
      rsp_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == flpte_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      rsp_valid <= rsp_load || (rsp_valid && rsp_stall);
      if (state == flpte_pkg::ST_CHECK && !leaf && !present &&
          req.cmd == flpte_pkg::CMD_MAP && can_alloc) begin
        next_free <= next_free + NFW'(1);
      end
      if (cfg_wr) begin
        case (paddr[2])
          flpte_pkg::REG_ROOT_TABLE_PAGE: begin
            root_table_page <= pwdata[flpte_pkg::ROOT_W-1:0];
          end
          default: begin
            first_free_page <= pwdata[flpte_pkg::FREE_W-1:0];
            next_free       <= NFW'(pwdata[flpte_pkg::FREE_W-1:0]);
          end
        endcase
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_beat.status        <= res_status;
      rsp_beat.phys_addr_out <= res_addr;
    end
    case (state)
      flpte_pkg::ST_IDLE: begin
        if (cmd_take) begin
          req        <= cmd_beat;
          level      <= 2'd0;
          page       <= PW'(root_table_page);
          res_status <= flpte_pkg::STATUS_ABSENT;
          res_addr   <= '0;
        end
      end
      flpte_pkg::ST_LOOKUP: begin
        if (leaf && req.cmd != flpte_pkg::CMD_TRANSLATE) res_status <= flpte_pkg::STATUS_OK;
      end
      flpte_pkg::ST_CHECK: begin
        if (leaf) begin
          if (present) begin
            res_status <= flpte_pkg::STATUS_OK;
            res_addr   <= {entry[flpte_pkg::PA_W-1:flpte_pkg::OFS_W],
                           req.virt_addr[flpte_pkg::OFS_W-1:0]};
          end
        end else if (present) begin
          if (ptr_ok) begin
            page  <= entry[flpte_pkg::OFS_W +: PW];
            level <= level + 2'd1;
          end
        end else if (req.cmd == flpte_pkg::CMD_MAP) begin
          if (can_alloc) begin
            page  <= next_free[PW-1:0];
            level <= level + 2'd1;
          end else begin
            res_status <= flpte_pkg::STATUS_ALLOC_FAIL;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/flpte_checker.sv =====
// Port-level checks for the page table engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module flpte_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          cmd_stall,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_stall,
  input wire flpte_pkg::rsp_beat_t          rsp_beat
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
    else $error("rsp beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_beat.status == flpte_pkg::STATUS_OK ||
                   rsp_beat.status == flpte_pkg::STATUS_ABSENT ||
                   rsp_beat.status == flpte_pkg::STATUS_ALLOC_FAIL))
    else $error("undefined status code");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_beat.status != flpte_pkg::STATUS_OK |-> rsp_beat.phys_addr_out == '0)
    else $error("address returned with failing status");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> cmd_stall)
    else $error("command taken during table clear");

endmodule

bind four_level_page_table_engine flpte_checker u_flpte_checker (.*);
`default_nettype wire

// ===== tb/sv/four_level_page_table_engine_tb.sv =====
// Self-checking testbench for the four-level page table engine: walks, allocation, faults.
`timescale 1ns / 1ps
module four_level_page_table_engine_tb;
  import flpte_pkg::*;

  localparam int TABLE_PAGES = 16;
  localparam int STORE_DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int QUIET_LIMIT = 40000;
  localparam int PHASE_ITEMS = 230;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_beat_t cmd_beat = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_beat_t rsp_beat;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  four_level_page_table_engine #(.TABLE_PAGES(TABLE_PAGES)) uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_beat(cmd_beat),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_beat(rsp_beat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // shadow of the table store and allocator
  logic [ENTRY_W-1:0] page_store [STORE_DEPTH];
  logic [ROOT_W-1:0] root_sel;
  logic [FREE_W-1:0] first_free;
  logic [FREE_W-1:0] alloc_next;

  cmd_beat_t cmd_backlog[$];
  rsp_beat_t walk_results[$];
  logic [VA_W-1:0] mapped_vas[$];

  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int cycle_cnt = 0;
  int quiet_cycles = 0;

  wire cmd_fire = cmd_valid && !cmd_stall;
  wire rsp_fire = rsp_valid && !rsp_stall;

  function automatic rsp_beat_t walk_tables(input cmd_beat_t b);
    rsp_beat_t r;
    int page;
    int lvl;
    int s;
    logic [ENTRY_W-1:0] e;
    logic [IDX_W-1:0] idx;
    r.status = STATUS_ABSENT;
    r.phys_addr_out = '0;
    if (b.cmd == CMD_RESERVED || root_sel >= TABLE_PAGES) return r;
    r.status = STATUS_OK;
    page = root_sel;
    for (lvl = 0; lvl < 3 && r.status == STATUS_OK; lvl++) begin
      idx = b.virt_addr[39 - 9 * lvl +: IDX_W];
      s = page * ENTRIES_PER_TABLE + idx;
      e = page_store[s];
      if (!e[0]) begin
        if (b.cmd != CMD_MAP) begin
          r.status = STATUS_ABSENT;
        end else if (alloc_next >= TABLE_PAGES) begin
          r.status = STATUS_ALLOC_FAIL;
        end else begin
          e = LINK_FLAGS | (64'(alloc_next) << OFS_W);
          page_store[s] = e;
          alloc_next++;
        end
      end
      if (r.status == STATUS_OK) begin
        if (e[PA_W-1:OFS_W] >= TABLE_PAGES) r.status = STATUS_ABSENT;
        else page = int'(e[PA_W-1:OFS_W]);
      end
    end
    if (r.status == STATUS_OK) begin
      s = page * ENTRIES_PER_TABLE + b.virt_addr[OFS_W +: IDX_W];
      case (b.cmd)
        CMD_MAP: begin
          page_store[s] = {{(ENTRY_W-PA_W){1'b0}}, b.phys_addr_in[PA_W-1:OFS_W],
                           {OFS_W{1'b0}}} | b.entry_flags;
        end
        CMD_UNMAP: begin
          page_store[s] = '0;
        end
        default: begin
          if (!page_store[s][0]) r.status = STATUS_ABSENT;
          else r.phys_addr_out = {page_store[s][PA_W-1:OFS_W], b.virt_addr[OFS_W-1:0]};
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  task automatic apb_write(input logic reg_sel, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_ROOT_TABLE_PAGE) begin
      root_sel = data[ROOT_W-1:0];
    end else begin
      first_free = data[FREE_W-1:0];
      alloc_next = first_free;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input int root, input int ff);
    apb_write(REG_ROOT_TABLE_PAGE, PDATA_W'(root));
    apb_write(REG_FIRST_FREE_PAGE, PDATA_W'(ff));
  endtask

  task automatic push_cmd(input logic [1:0] c, input logic [VA_W-1:0] va,
                          input logic [PA_W-1:0] pa, input logic [ENTRY_W-1:0] fl);
    cmd_beat_t b;
    b.cmd = c;
    b.virt_addr = va;
    b.phys_addr_in = pa;
    b.entry_flags = fl;
    cmd_backlog.push_back(b);
    if (c == CMD_MAP) begin
      mapped_vas.push_back(va);
      if (mapped_vas.size() > 32) void'(mapped_vas.pop_front());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || walk_results.size() != 0);
  endtask

  function automatic logic [IDX_W-1:0] level_pick();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 9'd1;
      2: return 9'd2;
      3: return '1;
      default: return IDX_W'($urandom);
    endcase
  endfunction

  // mostly shared paths so walks hit existing tables; some fully random addresses
  task automatic run_random_phase(input int n);
    int i;
    int r;
    logic [1:0] c;
    logic [VA_W-1:0] va;
    logic [PA_W-1:0] pa;
    logic [63:0] rnd;
    logic [ENTRY_W-1:0] fl;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      c = (r < 40) ? CMD_MAP : (r < 75) ? CMD_TRANSLATE : (r < 94) ? CMD_UNMAP : CMD_RESERVED;
      rnd = {$urandom, $urandom};
      if (mapped_vas.size() > 0 && c != CMD_MAP && $urandom_range(0, 2) != 0) begin
        va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
        va[OFS_W-1:0] = rnd[OFS_W-1:0];
      end else if ($urandom_range(0, 9) == 0) begin
        va = rnd[VA_W-1:0];
      end else begin
        va = {level_pick(), level_pick(), level_pick(), level_pick(), rnd[OFS_W-1:0]};
      end
      rnd = {$urandom, $urandom};
      pa = rnd[PA_W-1:0];
      if ($urandom_range(0, 1) == 1) pa[PA_W-1:OFS_W] = 40'($urandom_range(0, 31));
      rnd = {$urandom, $urandom};
      fl = rnd;
      if ($urandom_range(0, 1) == 1) begin
        fl = rnd & 64'hFFF0_0000_0000_0FFF;
        if ($urandom_range(0, 4) != 0) fl[0] = 1'b1;
      end
      push_cmd(c, va, pa, fl);
    end
  endtask

  // command driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_fire) walk_results.push_back(walk_tables(cmd_beat));
      if (cmd_valid && cmd_stall) begin
        cmd_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        cmd_beat <= cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // response monitor and stall pattern
  always @(posedge clk) begin
    cycle_cnt++;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_fire) begin
        if (walk_results.size() == 0) begin
          report_mismatch($sformatf("unexpected beat status=%0d pa=%h",
                                    rsp_beat.status, rsp_beat.phys_addr_out));
        end else begin
          rsp_beat_t want;
          want = walk_results.pop_front();
          if (rsp_beat.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      rsp_beat.status, want.status));
          if (rsp_beat.phys_addr_out !== want.phys_addr_out)
            report_mismatch($sformatf("phys_addr_out got %h want %h",
                                      rsp_beat.phys_addr_out, want.phys_addr_out));
        end
      end
      if (stall_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        2: rsp_stall <= ($urandom_range(0, 3) != 0);
        default: rsp_stall <= (cycle_cnt % 7) < 3;
      endcase
    end
  end

  always @(posedge clk) begin
    if (cmd_fire || rsp_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int k;
    for (k = 0; k < STORE_DEPTH; k++) page_store[k] = '0;
    root_sel = '0;
    first_free = 5'd1;
    alloc_next = 5'd1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (cmd_stall !== 1'b0);

    set_config(0, 1);
    push_cmd(CMD_TRANSLATE, '0, '0, '0);
    push_cmd(CMD_UNMAP, '0, '0, '0);
    push_cmd(CMD_MAP, '0, '1, 64'h1);
    push_cmd(CMD_TRANSLATE, 48'hFFF, '0, '0);
    push_cmd(CMD_MAP, 48'h1000, 52'h20000, 64'h1);
    push_cmd(CMD_MAP, '1, '0, '1);
    push_cmd(CMD_TRANSLATE, '1, '0, '0);
    push_cmd(CMD_UNMAP, '0, '0, '0);
    push_cmd(CMD_TRANSLATE, '0, '0, '0);
    push_cmd(CMD_UNMAP, '0, '0, '0);
    push_cmd(CMD_RESERVED, '1, '1, '1);
    push_cmd(CMD_MAP, 48'h4000_0000, 52'hA_5A5A_5A5A_5000, 64'h1);
    push_cmd(CMD_MAP, 48'h100_0000_0000, 52'h1234_5000, 64'h3);
    push_cmd(CMD_MAP, 48'h180_0000_0000, 52'h5_0000_0000_0000, 64'h8000_0000_0000_0001);
    push_cmd(CMD_MAP, 48'h200_0000_0000, 52'h7000, 64'h1);
    push_cmd(CMD_TRANSLATE, 48'h200_0000_0ABC, '0, '0);
    push_cmd(CMD_MAP, 48'h280_0000_0000, 52'h8000, 64'h1);
    push_cmd(CMD_MAP, '0, 52'h5_5555_5555_5555, '0);
    push_cmd(CMD_TRANSLATE, '0, '0, '0);
    wait_drained();

    // root on a leaf table: entries pointing past the store, allocator exhausted
    set_config(3, 16);
    push_cmd(CMD_TRANSLATE, 48'h80_0000_0000, '0, '0);
    push_cmd(CMD_MAP, 48'h80_0000_0000, 52'h9000, 64'h1);
    push_cmd(CMD_TRANSLATE, '0, '0, '0);
    push_cmd(CMD_MAP, 48'h300_0000_0000, 52'h9000, 64'h1);
    wait_drained();

    set_config(0, 1);
    run_random_phase(PHASE_ITEMS);
    wait_drained();
    set_config(15, 2);
    run_random_phase(PHASE_ITEMS);
    wait_drained();
    set_config($urandom_range(0, 15), $urandom_range(1, 16));
    run_random_phase(PHASE_ITEMS);
    wait_drained();
    set_config(7, 16);
    run_random_phase(PHASE_ITEMS);
    wait_drained();
    set_config($urandom_range(0, 15), 1);
    run_random_phase(PHASE_ITEMS);
    wait_drained();
    set_config($urandom_range(0, 15), $urandom_range(1, 16));
    run_random_phase(PHASE_ITEMS);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
